// ----- hw/rtl/sha1_hash_engine_assert.svh -----
// Assertion macros used by the SHA-1 engine RTL.
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SHA1_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1 assertion failed");
// Next-cycle implication, checked outside reset.
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1 assertion failed");
`else
`define SHA1_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/sha1_pkg.sv -----
package sha1_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_EMIT
    } t_state;

    typedef logic [4:0][31:0] t_hash;

    typedef struct packed {
        logic start;
        logic init;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    localparam t_hash H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_PHASE1 = 7'd20;
    localparam logic [6:0] ROUND_PHASE2 = 7'd40;
    localparam logic [6:0] ROUND_PHASE3 = 7'd60;
    localparam logic [6:0] ROUND_FINAL  = 7'd80;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] LAST_POS      = 6'd63;

endpackage

// ----- hw/rtl/sha1_round.sv -----
module sha1_round (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_e,
    input  logic [31:0] i_w,
    input  logic [6:0]  i_round,
    output logic [31:0] o_t
);

    logic [31:0] w_f;
    logic [31:0] w_k;

    always_comb begin
        if (i_round < sha1_pkg::ROUND_PHASE1) begin
            w_f = (i_b & i_c) | (~i_b & i_d);
            w_k = sha1_pkg::K_0;
        end else if (i_round < sha1_pkg::ROUND_PHASE2) begin
            w_f = i_b ^ i_c ^ i_d;
            w_k = sha1_pkg::K_1;
        end else if (i_round < sha1_pkg::ROUND_PHASE3) begin
            w_f = (i_b & i_c) | (i_b & i_d) | (i_c & i_d);
            w_k = sha1_pkg::K_2;
        end else begin
            w_f = i_b ^ i_c ^ i_d;
            w_k = sha1_pkg::K_3;
        end
    end

    assign o_t = {i_a[26:0], i_a[31:27]} + w_f + i_e + w_k + i_w;

endmodule

// ----- hw/rtl/sha1_core.sv -----
module sha1_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha1_pkg::t_core_ctl i_ctl,
    input  logic [511:0]        i_block,
    output sha1_pkg::t_core_sts o_sts,
    output sha1_pkg::t_hash     o_hash
);

    logic            r_busy;
    logic [6:0]      r_round;
    sha1_pkg::t_hash r_h;
    logic [31:0]     r_a, r_b, r_c, r_d, r_e;
    logic [31:0]     r_win [16];
    logic [31:0]     w_t;
    logic [31:0]     w_sched;
    logic            w_done;

    sha1_round u_round (
        .i_a     (r_a),
        .i_b     (r_b),
        .i_c     (r_c),
        .i_d     (r_d),
        .i_e     (r_e),
        .i_w     (r_win[0]),
        .i_round (r_round),
        .o_t     (w_t)
    );

    // Next schedule word, sixteen rounds ahead of the one in use.
    assign w_sched = {r_win[13][30:0] ^ r_win[8][30:0] ^ r_win[2][30:0] ^ r_win[0][30:0],
                      r_win[13][31] ^ r_win[8][31] ^ r_win[2][31] ^ r_win[0][31]};

    assign w_done = r_busy && (r_round == sha1_pkg::ROUND_FINAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
            r_h     <= sha1_pkg::H_INIT;
        end else begin
            if (i_ctl.init) begin
                r_h <= sha1_pkg::H_INIT;
            end
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (w_done) begin
                // fold the working variables into the chaining words
                r_busy <= 1'b0;
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end else if (r_busy) begin
                r_round <= r_round + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int i = 0; i < 16; i++) begin
                r_win[i] <= i_block[511 - 32 * i -: 32];
            end
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (r_busy && !w_done) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= w_sched;
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = w_done;
    assign o_hash     = r_h;

endmodule

// ----- hw/rtl/sha1_hash_engine.sv -----
// SHA-1 engine: hashes a byte stream into a 160-bit digest.
// Input channel (i_valid / o_stall): one item per beat carries an optional
// message byte (i_byte_present) and an optional end marker (i_message_end).
// An item with neither flag is taken and ignored.
// Output channel (o_valid / i_stall): one beat per message holding the digest
// as five big-endian words, word 0 first.
// Throughput: one byte per cycle while o_stall is low; every 64th byte stalls
// the input while the single shared round unit runs 80 rounds plus the
// chaining update. End of message: the 0x80 byte, zero bytes up to offset 56
// and the eight length bytes are absorbed in turn, each block (one or two)
// compressed as it fills, then the digest register is loaded. o_stall stays
// high throughout.
// The digest sits in its own output register, so the next message streams in
// while the receiver stalls; only a second digest waits until it is taken.
// Reset (i_rst_n low, synchronous) restores the initial chaining values,
// clears the bit count and drops any pending digest.
`include "sha1_hash_engine_assert.svh"

module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_message_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word0,
    output logic [31:0] o_digest_word1,
    output logic [31:0] o_digest_word2,
    output logic [31:0] o_digest_word3,
    output logic [31:0] o_digest_word4
);

    sha1_pkg::t_state    r_state, n_state;
    sha1_pkg::t_state    r_ret, n_ret;
    logic [5:0]          r_pos;
    logic [63:0]         r_count;
    logic [2:0]          r_len_idx;
    logic [511:0]        r_buf;
    logic                r_out_valid;
    sha1_pkg::t_hash     r_digest;

    logic                w_absorb;
    logic [7:0]          w_byte;
    logic                w_full;
    logic                w_load;
    sha1_pkg::t_core_ctl w_ctl;
    sha1_pkg::t_core_sts w_sts;
    sha1_pkg::t_hash     w_hash;
    logic [511:0]        w_block;

    assign w_full  = (r_pos == sha1_pkg::LAST_POS);
    assign w_block = {r_buf[503:0], w_byte};

    sha1_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_block (w_block),
        .o_sts   (w_sts),
        .o_hash  (w_hash)
    );

    // Datapath controls per state.
    always_comb begin
        w_absorb   = 1'b0;
        w_byte     = '0;
        w_load     = 1'b0;
        w_ctl.init = 1'b0;
        case (r_state)
            sha1_pkg::ST_IDLE: begin
                w_absorb = i_valid && i_byte_present;
                w_byte   = i_data_byte;
            end
            sha1_pkg::ST_PAD_MARK: begin
                w_absorb = 1'b1;
                w_byte   = sha1_pkg::PAD_MARK_BYTE;
            end
            sha1_pkg::ST_PAD_ZERO: begin
                w_absorb = (r_pos != sha1_pkg::LEN_POS);
            end
            sha1_pkg::ST_PAD_LEN: begin
                w_absorb = 1'b1;
                w_byte   = r_count[{~r_len_idx, 3'b000} +: 8];
            end
            sha1_pkg::ST_EMIT: begin
                w_load     = !r_out_valid || !i_stall;
                w_ctl.init = w_load;
            end
            default: begin
                w_absorb = 1'b0;
            end
        endcase
        w_ctl.start = w_absorb && w_full;
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            sha1_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_message_end ? sha1_pkg::ST_PAD_MARK : sha1_pkg::ST_IDLE;
                    if (w_ctl.start) begin
                        n_ret   = n_state;
                        n_state = sha1_pkg::ST_ROUND;
                    end
                end
            end
            sha1_pkg::ST_ROUND: begin
                if (w_sts.done) begin
                    n_state = r_ret;
                end
            end
            sha1_pkg::ST_PAD_MARK: begin
                n_state = sha1_pkg::ST_PAD_ZERO;
                if (w_full) begin
                    n_ret   = sha1_pkg::ST_PAD_ZERO;
                    n_state = sha1_pkg::ST_ROUND;
                end
            end
            sha1_pkg::ST_PAD_ZERO: begin
                if (r_pos == sha1_pkg::LEN_POS) begin
                    n_state = sha1_pkg::ST_PAD_LEN;
                end else if (w_full) begin
                    n_ret   = sha1_pkg::ST_PAD_ZERO;
                    n_state = sha1_pkg::ST_ROUND;
                end
            end
            sha1_pkg::ST_PAD_LEN: begin
                if (w_full) begin
                    n_ret   = sha1_pkg::ST_EMIT;
                    n_state = sha1_pkg::ST_ROUND;
                end
            end
            sha1_pkg::ST_EMIT: begin
                if (w_load) begin
                    n_state = sha1_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha1_pkg::ST_IDLE;
            r_ret       <= sha1_pkg::ST_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_len_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (w_absorb) begin
                r_pos <= r_pos + 6'd1;
            end
            // count only message bytes; padding reads the frozen total
            if (r_state == sha1_pkg::ST_IDLE && w_absorb) begin
                r_count <= r_count + 64'd8;
            end else if (w_load) begin
                r_count <= '0;
            end
            if (r_state == sha1_pkg::ST_PAD_LEN) begin
                r_len_idx <= r_len_idx + 3'd1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_absorb) begin
            r_buf <= w_block;
        end
        if (w_load) begin
            r_digest <= w_hash;
        end
    end

    assign o_stall        = (r_state != sha1_pkg::ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_digest_word0 = r_digest[0];
    assign o_digest_word1 = r_digest[1];
    assign o_digest_word2 = r_digest[2];
    assign o_digest_word3 = r_digest[3];
    assign o_digest_word4 = r_digest[4];

    `SHA1_ASSERT_IMPL(a_round_busy, i_clk, i_rst_n,
        r_state == sha1_pkg::ST_ROUND, w_sts.busy)
    `SHA1_ASSERT_IMPL(a_len_aligned, i_clk, i_rst_n,
        r_state == sha1_pkg::ST_PAD_LEN, r_pos[5:3] == 3'b111 && r_pos[2:0] == r_len_idx)
    `SHA1_ASSERT_NEXT(a_emit_waits, i_clk, i_rst_n,
        r_state == sha1_pkg::ST_EMIT && r_out_valid && i_stall,
        r_state == sha1_pkg::ST_EMIT)
    `SHA1_ASSERT_IMPL(a_no_start_busy, i_clk, i_rst_n,
        w_ctl.start, !w_sts.busy)

endmodule
